[src/six_channel_block_average_normalizer_assert.svh]
// Assertion macros for the block average normalizer.
`ifndef SIX_CHANNEL_BLOCK_AVERAGE_NORMALIZER_ASSERT_SVH
`define SIX_CHANNEL_BLOCK_AVERAGE_NORMALIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is high.
`define SBAN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check, active during reset as well.
`define SBAN_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBAN_ASSERT(label, clk, rst, prop, msg)
`define SBAN_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[src/sban_pkg.sv]
// Types, constants and helpers shared by the block average normalizer.
package sban_pkg;

   localparam int CHANNELS      = 6;
   localparam int WINDOW_LENGTH = 5;
   localparam int SAMPLE_BITS   = 12;

   localparam int SLOT_BITS   = 3;
   localparam int FS_BITS     = 12;
   localparam int SCALED_BITS = 14;
   localparam int CSR_INDEX_BITS = 3;

   localparam int DEPTH     = CHANNELS * WINDOW_LENGTH;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int K_BITS    = $clog2(WINDOW_LENGTH + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LENGTH);

   // floor(sum / WINDOW_LENGTH) as (sum * RECIP_M) >> RECIP_SHIFT, exact for SUM_BITS inputs
   localparam int RECIP_SHIFT = SUM_BITS + $clog2(WINDOW_LENGTH);
   localparam int RECIP_BITS  = RECIP_SHIFT + 1;
   localparam logic [RECIP_BITS-1:0] RECIP_M =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH);

   localparam logic [SCALED_BITS-1:0] SCALE_FACTOR = SCALED_BITS'(10000);
   localparam logic [SCALED_BITS-1:0] SCALE_SAT    = SCALED_BITS'(9999);

   // divider numerator: high part below full scale, low part shifted in one bit a step
   localparam int NUM_BITS     = FS_BITS + SCALED_BITS;
   localparam int DIV_CNT_BITS = $clog2(SCALED_BITS + 1);

   // csr map: full scale of channel i at index CSR_FULL_SCALE_BASE + i
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_SCALE_BASE = '0;

   localparam logic [FS_BITS-1:0] FS_RESET [8] = '{
      FS_BITS'(2000), FS_BITS'(2000), FS_BITS'(2000), FS_BITS'(2000),
      FS_BITS'(3000), FS_BITS'(3000), FS_BITS'(2000), FS_BITS'(2000)
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_RECIP,
      ST_SCALE_MUL,
      ST_DIVIDE,
      ST_FINISH
   } sban_state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]   slot_index;
      logic [SAMPLE_BITS-1:0] sample_ch0;
      logic [SAMPLE_BITS-1:0] sample_ch1;
      logic [SAMPLE_BITS-1:0] sample_ch2;
      logic [SAMPLE_BITS-1:0] sample_ch3;
      logic [SAMPLE_BITS-1:0] sample_ch4;
      logic [SAMPLE_BITS-1:0] sample_ch5;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] average_ch0;
      logic [SAMPLE_BITS-1:0] average_ch1;
      logic [SAMPLE_BITS-1:0] average_ch2;
      logic [SAMPLE_BITS-1:0] average_ch3;
      logic [SAMPLE_BITS-1:0] average_ch4;
      logic [SAMPLE_BITS-1:0] average_ch5;
      logic [SCALED_BITS-1:0] scaled_ch0;
      logic [SCALED_BITS-1:0] scaled_ch1;
      logic [SCALED_BITS-1:0] scaled_ch2;
      logic [SCALED_BITS-1:0] scaled_ch3;
      logic [SCALED_BITS-1:0] scaled_ch4;
      logic [SCALED_BITS-1:0] scaled_ch5;
   } rsp_type;

   typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_type;
   typedef logic [CHANNELS-1:0][SCALED_BITS-1:0] scaled_vec_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic sample_vec_type req_samples(req_type r);
      sample_vec_type v;
      v[0] = r.sample_ch0;
      v[1] = r.sample_ch1;
      v[2] = r.sample_ch2;
      v[3] = r.sample_ch3;
      v[4] = r.sample_ch4;
      v[5] = r.sample_ch5;
      return v;
   endfunction

   function automatic rsp_type pack_rsp(sample_vec_type a, scaled_vec_type s);
      rsp_type r;
      r.average_ch0 = a[0];
      r.average_ch1 = a[1];
      r.average_ch2 = a[2];
      r.average_ch3 = a[3];
      r.average_ch4 = a[4];
      r.average_ch5 = a[5];
      r.scaled_ch0  = s[0];
      r.scaled_ch1  = s[1];
      r.scaled_ch2  = s[2];
      r.scaled_ch3  = s[3];
      r.scaled_ch4  = s[4];
      r.scaled_ch5  = s[5];
      return r;
   endfunction

endpackage

[src/sban_window_ram.sv]
// Sample window memory: one write port, one registered read port.
module sban_window_ram
   import sban_pkg::*;
(
   input  logic                   clock,
   input  logic                   we,
   input  logic [ADDR_BITS-1:0]   waddr,
   input  logic [SAMPLE_BITS-1:0] wdata,
   input  logic                   re,
   input  logic [ADDR_BITS-1:0]   raddr,
   output logic [SAMPLE_BITS-1:0] rdata
);

   logic [SAMPLE_BITS-1:0] mem_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

[src/sban_divider.sv]
// Restoring divider, one quotient bit per cycle.
module sban_divider
   import sban_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_BITS-1:0]    num,
   input  logic [FS_BITS-1:0]     den,
   output div_status_type         status,
   output logic [SCALED_BITS-1:0] quot
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [FS_BITS-1:0]      rem_ff, rem_in;
   logic [SCALED_BITS-1:0]  lo_ff, lo_in;
   logic [FS_BITS-1:0]      den_ff, den_in;

   logic [FS_BITS:0] trial;
   logic [FS_BITS:0] diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, lo_ff[SCALED_BITS-1]};
      ge    = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num[NUM_BITS-1:SCALED_BITS];
         lo_in   = num[SCALED_BITS-1:0];
         den_in  = den;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits FS_BITS
         rem_in = ge ? diff[FS_BITS-1:0] : trial[FS_BITS-1:0];
         lo_in  = {lo_ff[SCALED_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(SCALED_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = lo_ff;

endmodule

[src/six_channel_block_average_normalizer.sv]
// Top level of the six-channel block average normalizer.
// Frame with slot 0..3: the item is accepted, then written one channel per memory write.
// Slot 4: the writes, then per channel the window reads, a reciprocal multiply, a scale step
// and the divider (skipped when saturated), then the result is loaded into the output register.
// Out-of-range slot: dropped, no result. A new item is taken only once the block is back in idle.
// Synchronous active-high reset clears window valid bits, full scales to defaults, no item.
`include "six_channel_block_average_normalizer_assert.svh"

module six_channel_block_average_normalizer
   import sban_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // result items
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // full scale registers
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FS_BITS-1:0]        csr_data
);

   localparam int PROD_BITS       = SUM_BITS + RECIP_BITS;
   localparam int SCALE_PROD_BITS = SAMPLE_BITS + SCALED_BITS;

   // ---------------------------------------------------------------- state
   sban_state_type state_ff, state_in;

   req_type                item_ff, item_in;
   logic [CH_BITS-1:0]     ch_ff, ch_in;        // channel being worked on
   logic [ADDR_BITS-1:0]   base_ff, base_in;    // ch_ff * WINDOW_LENGTH
   logic [K_BITS-1:0]      k_ff, k_in;          // read slot counter
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [DEPTH-1:0]       win_valid_ff, win_valid_in;  // entry written since reset
   logic                   rd_valid_ff, rd_valid_in;    // travels with the ram read data
   logic [FS_BITS-1:0]     fs_ff [CHANNELS];
   logic [FS_BITS-1:0]     fs_in [CHANNELS];
   sample_vec_type         res_avg_ff, res_avg_in;
   scaled_vec_type         res_scl_ff, res_scl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- control
   logic                   req_accept;
   logic                   ram_we;
   logic                   ram_re;
   logic [ADDR_BITS-1:0]   ram_waddr;
   logic [ADDR_BITS-1:0]   ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   sample_vec_type         item_samples;
   logic                   last_ch;
   logic                   last_slot;
   logic                   slot_ok;
   logic                   sat;
   logic                   div_start;
   logic                   chan_done;
   logic                   rsp_load;
   logic                   enter_read;

   // ---------------------------------------------------------------- datapath
   logic [PROD_BITS-1:0]       recip_prod;
   logic [SCALE_PROD_BITS-1:0] scale_prod;
   logic [NUM_BITS-1:0]        div_num;
   div_status_type             div_status;
   logic [SCALED_BITS-1:0]     div_quot;
   logic [SCALED_BITS-1:0]     scl_value;
   logic [SAMPLE_BITS-1:0]     rd_sample;

   assign item_samples = req_samples(item_ff);
   assign last_ch      = ch_ff == CH_BITS'(CHANNELS - 1);
   assign last_slot    = item_ff.slot_index == SLOT_BITS'(WINDOW_LENGTH - 1);
   assign slot_ok      = req_data.slot_index < SLOT_BITS'(WINDOW_LENGTH);
   assign sat          = avg_ff >= fs_ff[ch_ff];

   // window mean via the reciprocal, exact over the whole sum range
   assign recip_prod = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP_M);

   // avg < full scale here, so the product fits NUM_BITS and the quotient SCALED_BITS
   assign scale_prod = SCALE_PROD_BITS'(avg_ff) * SCALE_PROD_BITS'(SCALE_FACTOR);
   assign div_num    = NUM_BITS'(scale_prod);

   assign rd_sample = rd_valid_ff ? ram_rdata : '0;
   assign scl_value = sat ? SCALE_SAT : div_quot;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = slot_ok ? ST_WRITE : ST_IDLE;
            end
         end
         ST_WRITE: begin
            if (last_ch) begin
               state_in = last_slot ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            if (k_ff == K_BITS'(WINDOW_LENGTH)) begin
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            state_in = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            if (sat) begin
               state_in = last_ch ? ST_FINISH : ST_READ;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = last_ch ? ST_FINISH : ST_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- state outputs
   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      div_start = 1'b0;
      chan_done = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_WRITE: begin
            ram_we = 1'b1;
         end
         ST_READ: begin
            ram_re = k_ff < K_BITS'(WINDOW_LENGTH);
         end
         ST_RECIP: begin
         end
         ST_SCALE_MUL: begin
            div_start = !sat;
            chan_done = sat;
         end
         ST_DIVIDE: begin
            chan_done = div_status.done;
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign enter_read = (ram_we && last_ch && last_slot) || (chan_done && !last_ch);

   assign ram_waddr = base_ff + ADDR_BITS'(item_ff.slot_index);
   assign ram_raddr = base_ff + ADDR_BITS'(k_ff);
   assign ram_wdata = item_samples[ch_ff];

   // ---------------------------------------------------------------- register updates
   always_comb begin
      item_in      = item_ff;
      ch_in        = ch_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      win_valid_in = win_valid_ff;
      rd_valid_in  = rd_valid_ff;
      fs_in        = fs_ff;
      res_avg_in   = res_avg_ff;
      res_scl_in   = res_scl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (req_accept) begin
         item_in = req_data;
         ch_in   = '0;
         base_in = '0;
      end

      // channel walk, shared by the write pass and the read pass
      if (ram_we || chan_done) begin
         if (last_ch) begin
            ch_in   = '0;
            base_in = '0;
         end else begin
            ch_in   = ch_ff + 1'b1;
            base_in = base_ff + ADDR_BITS'(WINDOW_LENGTH);
         end
      end

      if (ram_we) begin
         win_valid_in[ram_waddr] = 1'b1;
      end

      if (enter_read) begin
         k_in   = '0;
         sum_in = '0;
      end else if (state_ff == ST_READ) begin
         if (ram_re) begin
            k_in = k_ff + 1'b1;
         end
         // data of slot k_ff-1 is back from the ram now
         if (k_ff != '0) begin
            sum_in = sum_ff + SUM_BITS'(rd_sample);
         end
      end

      if (ram_re) begin
         rd_valid_in = win_valid_ff[ram_raddr];
      end

      if (state_ff == ST_RECIP) begin
         avg_in = SAMPLE_BITS'(recip_prod >> RECIP_SHIFT);
      end

      if (chan_done) begin
         res_avg_in[ch_ff] = avg_ff;
         res_scl_in[ch_ff] = scl_value;
      end

      // output register: a finished result waits here while the next item is taken
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pack_rsp(res_avg_ff, res_scl_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // indexes past the last channel are dropped
      if (csr_valid && csr_ready &&
          (csr_index - CSR_FULL_SCALE_BASE) < CSR_INDEX_BITS'(CHANNELS)) begin
         fs_in[CH_BITS'(csr_index - CSR_FULL_SCALE_BASE)] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         base_ff      <= '0;
         k_ff         <= '0;
         win_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            fs_ff[c] <= FS_RESET[c % 8];
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         base_ff      <= base_in;
         k_ff         <= k_in;
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fs_ff        <= fs_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
      rd_valid_ff <= rd_valid_in;
      res_avg_ff  <= res_avg_in;
      res_scl_ff  <= res_scl_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- units
   sban_window_ram u_window_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sban_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (fs_ff[ch_ff]),
      .status (div_status),
      .quot   (div_quot)
   );

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   `SBAN_ASSERT(a_div_start_idle, clock, reset, div_start |-> !div_status.busy, "divider restarted while busy")
   `SBAN_ASSERT(a_done_in_divide, clock, reset, div_status.done |-> (state_ff == ST_DIVIDE), "divider done outside divide state")
   `SBAN_ASSERT(a_rsp_last_slot, clock, reset, rsp_load |-> last_slot, "result from a frame that is not the last slot")
   `SBAN_ASSERT(a_scaled_range, clock, reset, chan_done |-> (scl_value <= SCALE_SAT), "scaled value above saturation")

endmodule
